/* rtl/core/polyphase_rational_resampler_top_macros.svh */
// Assertion macros shared by the resampler RTL
`ifndef POLYPHASE_RATIONAL_RESAMPLER_TOP_MACROS_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_TOP_MACROS_SVH

`ifndef SYNTH
// checked property, disabled while reset is asserted
`define PRR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("resampler assertion failed");
// checked property, also evaluated during reset
`define PRR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("resampler assertion failed");
`else
`define PRR_ASSERT(lbl, prop)
`define PRR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/core/prr_pkg.sv */
// Types, constants and arithmetic helpers of the polyphase resampler
package prr_pkg;

  localparam int TAPS      = 16;
  localparam int MAX_UP    = 16;
  localparam int MAX_DOWN  = 64;
  localparam int TAP_DEPTH = TAPS * MAX_UP;
  localparam int TAP_AW    = $clog2(TAP_DEPTH);
  localparam int HIST_AW   = $clog2(TAPS);
  localparam int SMP_W     = 16;
  localparam int UP_W      = 5;
  localparam int DOWN_W    = 7;
  localparam int PH_W      = $clog2(MAX_UP + MAX_DOWN);
  localparam int CNT_W     = $clog2(TAPS + 1);
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + $clog2(TAPS);
  localparam int FRAC_W    = 15;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = DOWN_W;

  localparam logic [CFG_AW-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_UP     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_DOWN   = 2'd2;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = -ACC_W'(32768);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TAP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  function automatic logic signed [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    r = (acc + ROUND_BIAS) >>> FRAC_W;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return r[SMP_W-1:0];
  endfunction

  function automatic logic [UP_W-1:0] clamp_up(input logic [UP_W-1:0] v);
    logic [UP_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = UP_W'(1);
    end else if (v > UP_W'(MAX_UP)) begin
      r = UP_W'(MAX_UP);
    end
    return r;
  endfunction

  function automatic logic [DOWN_W-1:0] clamp_down(input logic [DOWN_W-1:0] v);
    logic [DOWN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DOWN_W'(1);
    end else if (v > DOWN_W'(MAX_DOWN)) begin
      r = DOWN_W'(MAX_DOWN);
    end
    return r;
  endfunction

endpackage

/* rtl/core/prr_ram.sv */
// Generic single write port, single read port RAM with registered read
module prr_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/polyphase_rational_resampler_top.sv */
// Polyphase rational resampler: history and tap memories, shared MAC, control
// Samples enter a 16-entry history memory; taps sit in a 256-entry memory loaded by
// tap-write requests. With enable set, each sample yields between 0 and L outputs; each
// output is one pass of the single shared multiply-accumulate over 16 taps, one history
// and one tap read per cycle. Tap writes, clears, no-ops and samples that yield no output
// are handled without leaving the idle state; with enable clear a sample passes straight
// through. The input is stalled while outputs of a sample are still being made or one
// waits for the output register; one finished output may wait in the output register.
// Configuration must only be written while idle.
module polyphase_rational_resampler_top
  import prr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_AW-1:0]        cfg_index_i,
  input  logic [CFG_DW-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic signed [SMP_W-1:0]  sample_in_i,
  input  logic [TAP_AW-1:0]        tap_index_i,
  input  logic signed [SMP_W-1:0]  tap_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [SMP_W-1:0]  sample_out_o,
  output logic                     last_of_run_o
);

  `include "polyphase_rational_resampler_top_macros.svh"

  // configuration
  logic              en_q;
  logic [UP_W-1:0]   up_q;
  logic [DOWN_W-1:0] down_q;

  // control
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [HIST_AW-1:0] idx_q, idx_d;
  logic [TAP_AW-1:0]  addr_q, addr_d;
  logic [HIST_AW-1:0] newest_q, newest_d;
  logic [HIST_AW-1:0] head_q, head_d;
  logic [PH_W-1:0]    phase_q, phase_d;
  logic [PH_W-1:0]    ph_q, ph_d;
  logic [TAPS-1:0]    hv_q, hv_d;
  logic               rd_vld_q, rd_vld_d;
  logic               prod_vld_q, prod_vld_d;
  logic               out_vld_q, out_vld_d;

  // datapath
  logic                     hv_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SMP_W-1:0]  res_q, res_d;
  logic                     res_last_q, res_last_d;
  logic signed [SMP_W-1:0]  out_data_q, out_data_d;
  logic                     out_last_q, out_last_d;

  logic [UP_W-1:0]          l_eff;
  logic [DOWN_W-1:0]        m_eff;
  logic [PH_W-1:0]          ph_next;
  logic                     next_last;
  logic                     in_acc, out_free, issue, finish, mac_start;
  logic                     hist_we, tap_we;
  logic [SMP_W-1:0]         hist_rdata, tap_rdata;
  logic signed [SMP_W-1:0]  hist_val;
  logic signed [SMP_W-1:0]  mac_res;
  cmd_e                     cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      up_q   <= UP_W'(1);
      down_q <= DOWN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ENABLE: en_q   <= cfg_data_i[0];
        CFG_UP:     up_q   <= cfg_data_i[UP_W-1:0];
        CFG_DOWN:   down_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign l_eff      = clamp_up(up_q);
  assign m_eff      = clamp_down(down_q);
  assign cmd        = cmd_e'(command_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign issue      = (state_q == ST_MAC) && (cnt_q < CNT_W'(TAPS));
  assign finish     = (state_q == ST_MAC) && (cnt_q == CNT_W'(TAPS)) && !rd_vld_q
                      && !prod_vld_q;
  assign ph_next    = ph_q + PH_W'(m_eff);
  assign next_last  = (ph_next >= PH_W'(l_eff));
  assign mac_res    = round_sat(acc_q);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    addr_d     = addr_q;
    newest_d   = newest_q;
    head_d     = head_q;
    phase_d    = phase_q;
    ph_d       = ph_q;
    hv_d       = hv_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    res_d      = res_q;
    res_last_d = res_last_q;
    hist_we    = 1'b0;
    tap_we     = 1'b0;
    mac_start  = 1'b0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    rd_vld_d   = issue;
    prod_vld_d = rd_vld_q;
    if (issue) begin
      cnt_d  = cnt_q + CNT_W'(1);
      idx_d  = idx_q - HIST_AW'(1);
      addr_d = addr_q + TAP_AW'(l_eff);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_SAMPLE: begin
              if (!en_q) begin
                res_d      = sample_in_i;
                res_last_d = 1'b1;
                if (out_free) begin
                  out_vld_d  = 1'b1;
                  out_data_d = sample_in_i;
                  out_last_d = 1'b1;
                end else begin
                  state_d = ST_OUT;
                end
              end else begin
                hist_we      = 1'b1;
                hv_d[head_q] = 1'b1;
                head_d       = head_q + HIST_AW'(1);
                if (phase_q < PH_W'(l_eff)) begin
                  ph_d      = phase_q;
                  newest_d  = head_q;
                  idx_d     = head_q;
                  addr_d    = TAP_AW'(phase_q);
                  cnt_d     = '0;
                  mac_start = 1'b1;
                  state_d   = ST_MAC;
                end else begin
                  phase_d = phase_q - PH_W'(l_eff);
                end
              end
            end
            CMD_TAP: tap_we = 1'b1;
            CMD_CLEAR: begin
              hv_d    = '0;
              head_d  = '0;
              phase_d = '0;
            end
            CMD_NOP: ;
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        if (finish) begin
          res_d      = mac_res;
          res_last_d = next_last;
          if (next_last) begin
            phase_d = ph_next - PH_W'(l_eff);
          end else begin
            ph_d = ph_next;
          end
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_data_d = mac_res;
            out_last_d = next_last;
            if (next_last) begin
              state_d = ST_IDLE;
            end else begin
              idx_d     = newest_q;
              addr_d    = TAP_AW'(ph_next);
              cnt_d     = '0;
              mac_start = 1'b1;
            end
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = res_q;
          out_last_d = res_last_q;
          if (res_last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d     = newest_q;
            addr_d    = TAP_AW'(ph_q);
            cnt_d     = '0;
            mac_start = 1'b1;
            state_d   = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      addr_q     <= '0;
      newest_q   <= '0;
      head_q     <= '0;
      phase_q    <= '0;
      ph_q       <= '0;
      hv_q       <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      addr_q     <= addr_d;
      newest_q   <= newest_d;
      head_q     <= head_d;
      phase_q    <= phase_d;
      ph_q       <= ph_d;
      hv_q       <= hv_d;
      rd_vld_q   <= rd_vld_d;
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // unwritten history entries read as zero
  assign hist_val = hv_rd_q ? $signed(hist_rdata) : '0;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      hv_rd_q <= hv_q[idx_q];
    end
    if (rd_vld_q) begin
      prod_q <= hist_val * $signed(tap_rdata);
    end
    if (mac_start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    res_q      <= res_d;
    res_last_q <= res_last_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  prr_ram #(
    .Width(SMP_W),
    .Depth(TAPS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(head_q),
    .wdata_i(sample_in_i),
    .re_i   (issue),
    .raddr_i(idx_q),
    .rdata_o(hist_rdata)
  );

  prr_ram #(
    .Width(SMP_W),
    .Depth(TAP_DEPTH)
  ) u_tap_ram (
    .clk_i  (clk_i),
    .we_i   (tap_we),
    .waddr_i(tap_index_i),
    .wdata_i(tap_value_i),
    .re_i   (issue),
    .raddr_i(addr_q),
    .rdata_o(tap_rdata)
  );

  assign out_valid_o   = out_vld_q;
  assign sample_out_o  = out_data_q;
  assign last_of_run_o = out_last_q;

  `PRR_ASSERT(a_phase_bound, phase_q < PH_W'(MAX_UP + MAX_DOWN))
  `PRR_ASSERT(a_idle_pipe_empty, (state_q == ST_IDLE) |-> (!rd_vld_q && !prod_vld_q))
  `PRR_ASSERT(a_branch_in_range, (state_q == ST_MAC && cnt_q == '0) |-> (ph_q < PH_W'(l_eff)))
  `PRR_ASSERT(a_park_only_when_busy, (state_q == ST_OUT) |-> out_vld_q)

endmodule

/* bench/polyphase_rational_resampler_top_tb.sv */
// Self-checking bench for the polyphase rational resampler, with its own scoreboard
module polyphase_rational_resampler_top_tb;
  import prr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE_LIMIT = 400;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct packed {
    logic signed [SMP_W-1:0] value;
    logic                    last;
  } sample_t;

  class polyphase_scoreboard;
    logic signed [SMP_W-1:0] taps [TAP_DEPTH];
    logic signed [SMP_W-1:0] hist [TAPS];
    logic [HIST_AW-1:0]      head;
    logic [6:0]              phase;
    logic                    enable;
    logic [UP_W-1:0]         up;
    logic [DOWN_W-1:0]       down;
    sample_t                 due_samples [$];
    int errors, n_requests, n_checked, n_sat, n_silent;

    function new();
      foreach (taps[i]) taps[i] = '0;
      foreach (hist[i]) hist[i] = '0;
      head   = '0;
      phase  = '0;
      enable = 1'b0;
      up     = 5'd1;
      down   = 7'd1;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_ENABLE: enable = data[0];
        CFG_UP:     up = data[UP_W-1:0];
        CFG_DOWN:   down = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_samples.size();
    endfunction

    // one polyphase branch: dot product of the history with every L-th tap
    function logic signed [SMP_W-1:0] branch_output(logic [7:0] ph, logic [UP_W-1:0] l);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] r;
      logic [HIST_AW-1:0]      idx;
      int                      ta;
      acc = '0;
      idx = head - 4'd1;
      for (int k = 0; k < TAPS; k++) begin
        ta  = k * l + ph;
        acc += hist[idx] * taps[ta];
        idx = idx - 4'd1;
      end
      r = (acc + 36'sd16384) >>> 15;
      if (r > 36'sd32767) begin
        n_sat++;
        return 16'sh7FFF;
      end
      if (r < -36'sd32768) begin
        n_sat++;
        return 16'sh8000;
      end
      return r[SMP_W-1:0];
    endfunction

    function void take_request(logic [1:0] cmd, logic signed [SMP_W-1:0] smp,
                               logic [TAP_AW-1:0] tidx, logic signed [SMP_W-1:0] tval);
      logic [UP_W-1:0]   l;
      logic [DOWN_W-1:0] m;
      logic [7:0]        ph;
      int                n;
      sample_t           r;
      n_requests++;
      case (cmd_e'(cmd))
        CMD_TAP: taps[tidx] = tval;
        CMD_CLEAR: begin
          foreach (hist[i]) hist[i] = '0;
          head  = '0;
          phase = '0;
        end
        CMD_SAMPLE: begin
          if (!enable) begin
            r.value = smp;
            r.last  = 1'b1;
            due_samples.push_back(r);
          end else begin
            l = (up == 5'd0) ? 5'd1 : ((up > 5'd16) ? 5'd16 : up);
            m = (down == 7'd0) ? 7'd1 : ((down > 7'd64) ? 7'd64 : down);
            hist[head] = smp;
            head = head + 4'd1;
            ph = 8'(phase);
            n  = 0;
            if (ph >= 8'(l)) n_silent++;
            while (ph < 8'(l) && n < MAX_UP) begin
              r.value = branch_output(ph, l);
              r.last  = (ph + 8'(m) >= 8'(l)) || (n == MAX_UP - 1);
              due_samples.push_back(r);
              n++;
              ph = ph + 8'(m);
            end
            phase = 7'(ph - 8'(l));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic signed [SMP_W-1:0] v, logic last);
      sample_t e;
      if (due_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output: sample %0d last %0b", v, last);
        return;
      end
      e = due_samples.pop_front();
      n_checked++;
      if (e.value !== v || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                   e.value, e.last, v, last);
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_AW-1:0]       cfg_index_i;
  logic [CFG_DW-1:0]       cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              command_i;
  logic signed [SMP_W-1:0] sample_in_i;
  logic [TAP_AW-1:0]       tap_index_i;
  logic signed [SMP_W-1:0] tap_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [SMP_W-1:0] sample_out_o;
  logic                    last_of_run_o;

  polyphase_scoreboard sb = new();
  bit no_idle;
  bit hold_req;
  int cycles;
  int n_settings;

  polyphase_rational_resampler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .sample_in_i   (sample_in_i),
    .tap_index_i   (tap_index_i),
    .tap_value_i   (tap_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .last_of_run_o (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // request is noted before the output check of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.take_request(command_i, sample_in_i, tap_index_i, tap_value_i);
      if (out_valid_o && !out_stall_i)
        sb.check_output(sample_out_o, last_of_run_o);
    end
  end

  // receiver back-pressure
  initial begin
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 19);
        case ($urandom_range(0, 5))
          0, 1: out_stall_i <= 1'b1;
          2: begin
            out_stall_i <= 1'b0;
            n = 150;
          end
          default: out_stall_i <= 1'b0;
        endcase
        repeat (n) @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [SMP_W-1:0] rand_tap();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 4095)) - 16'sd2048;
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // called on a clock edge; returns on the edge the request is taken, or after a random idle gap that follows it
  task automatic send(cmd_e c, logic signed [SMP_W-1:0] s, logic [TAP_AW-1:0] ti,
                      logic signed [SMP_W-1:0] tv);
    in_valid_i  <= 1'b1;
    command_i   <= c;
    sample_in_i <= s;
    tap_index_i <= ti;
    tap_value_i <= tv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(logic signed [SMP_W-1:0] s);
    send(CMD_SAMPLE, s, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) send_sample(rand_sample());
    else if (r < 90) send(CMD_TAP, 16'($urandom), 8'($urandom_range(0, 255)), rand_tap());
    else if (r < 95) send(CMD_CLEAR, 16'($urandom), 8'($urandom), 16'($urandom));
    else send(CMD_NOP, 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // one edge first, so a request taken on the calling edge is already noted
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_LIMIT) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [CFG_DW-1:0] en_d, logic [CFG_DW-1:0] up_d,
                         logic [CFG_DW-1:0] down_d);
    logic [CFG_AW-1:0] idx [3];
    logic [CFG_DW-1:0] dat [3];
    idx = '{CFG_ENABLE, CFG_UP, CFG_DOWN};
    dat = '{en_d, up_d, down_d};
    for (int r = 0; r < 3; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[r];
      cfg_data_i  <= dat[r];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(idx[r], dat[r]);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [CFG_DW-1:0] up_d, down_d, en_d;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    command_i   = CMD_NOP;
    sample_in_i = '0;
    tap_index_i = '0;
    tap_value_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through after reset
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send(CMD_NOP, 16'sh1234, 8'hFF, 16'sh7FFF);
    send(CMD_CLEAR, 16'sh0000, 8'h00, 16'sh0000);
    send_sample(16'sh0000);

    // whole tap table, so no branch reads an unwritten coefficient
    for (int i = 0; i < TAP_DEPTH; i++) send(CMD_TAP, 16'($urandom), 8'(i), rand_tap());

    drain();
    set_cfg(7'd1, 7'd1, 7'd1);
    send(CMD_TAP, 16'sh0000, 8'h00, 16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send(CMD_TAP, 16'sh0000, 8'h00, 16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send(CMD_CLEAR, 16'sh7FFF, 8'h00, 16'sh0000);
    send(CMD_NOP, 16'sh8000, 8'hFF, 16'sh8000);

    drain();
    set_cfg(7'd1, 7'd0, 7'd0);
    send_sample(rand_sample());
    send_sample(rand_sample());

    drain();
    set_cfg(7'd1, 7'd31, 7'd127);
    repeat (3) send_sample(rand_sample());

    drain();
    set_cfg(7'd1, 7'd16, 7'd1);
    repeat (2) send_sample(rand_sample());

    drain();
    set_cfg(7'd1, 7'd2, 7'd5);
    repeat (3) send_sample(rand_sample());

    drain();
    set_cfg(7'd0, 7'd2, 7'd5);
    send_sample(rand_sample());

    for (int p = 0; p < 8; p++) begin
      drain();
      en_d = {6'($urandom_range(0, 63)), 1'b1};
      up_d = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(1, 16));
      case ($urandom_range(0, 3))
        0: down_d = 7'($urandom_range(0, 127));
        1: down_d = 7'($urandom_range(1, 64));
        default: down_d = 7'($urandom_range(1, 4));
      endcase
      if (p == 0) begin
        up_d   = 7'd16;
        down_d = 7'd1;
      end
      if (p == 6) en_d[0] = 1'b0;
      if (p == 7) no_idle = 1'b1;
      set_cfg(en_d, up_d, down_d);
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < 25; i++) begin
        if (p == 3 && i == 12) drain();
        send_random();
      end
    end

    drain();
    $display("covered %0d requests over %0d register settings, %0d output samples checked",
             sb.n_requests, n_settings, sb.n_checked);
    $display("%0d outputs saturated, %0d samples fell between output phases",
             sb.n_sat, sb.n_silent);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors, %0d outputs still awaited", sb.errors, sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
